### src/buddy_page_allocator_defines.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define BPA_ASSERT_IMPL(label, clk, rst_n, prop)
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### src/bpa_pkg.sv
// Shared types, constants and commands for the buddy page allocator.
`default_nettype none
package bpa_pkg;
    localparam int PAGES      = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int PW         = $clog2(PAGES);
    localparam int LW         = PW + 1;
    localparam int SLOTS      = 16;
    localparam int MAX_LEVELS = PW + 1;
    localparam logic [LW-1:0] NIL = '1;
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [5:0] TAG_START = 6'h20;
    localparam logic [5:0] TAG_ALLOC = 6'h10;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_A_SCAN, S_A_RM, S_A_SPLIT, S_A_DONE,
        S_F_RD, S_F_WAIT, S_F_CHK, S_F_BUD, S_F_BWAIT, S_F_BCHK,
        S_F_RM, S_F_PUSH, S_OUT
    } state_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_INIT, OP_LOAD, OP_SCAN, OP_A_RM, OP_SPLIT,
        OP_A_DONE, OP_F_RD, OP_F_CHK, OP_B_RD, OP_B_CHK, OP_RM, OP_PUSH,
        OP_FAIL
    } op_t;

    typedef struct packed {
        op_t op;
        logic [1:0] sub;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_hit;
        logic scan_end;
        logic too_large;
        logic split_done;
        logic fbad;
        logic merge_ok;
        logic merge_end;
        logic sub_done;
    } stat_t;
endpackage
`default_nettype wire

### src/bpa_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### src/bpa_datapath.sv
// Datapath: tag and link memories, free heads, level and page registers.
`default_nettype none
module bpa_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bpa_pkg::cmd_t         cmd,
    input  wire logic [3:0]            eff_levels,
    input  wire logic                  in_command,
    input  wire logic [30:0]           in_bytes,
    input  wire logic [bpa_pkg::PW-1:0] in_page,
    output bpa_pkg::stat_t             stat,
    output logic [1:0]                 res_status,
    output logic [bpa_pkg::PW-1:0]     res_page,
    output logic [3:0]                 res_level
);
    localparam int PW = bpa_pkg::PW;
    localparam int LW = bpa_pkg::LW;

    logic [LW-1:0] head_reg [bpa_pkg::SLOTS];
    logic [3:0]    cur_reg, req_reg;
    logic [PW-1:0] blk_reg, off_reg, bud_reg;
    logic [LW-1:0] n_reg, p_reg;
    logic [1:0]    rs_reg;
    logic [PW-1:0] rp_reg;
    logic [3:0]    rl_reg;
    logic [PW:0]   clr_reg;
    logic          big_reg, cmd_reg;

    // Memory ports.
    logic          tag_we, nx_we, pv_we;
    logic [PW-1:0] tag_a, nx_a, pv_a;
    logic [5:0]    tag_wd, tag_rd;
    logic [LW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

    bpa_ram #(.WIDTH(6), .DEPTH(bpa_pkg::PAGES)) u_tag (
        .clk(clk), .we(tag_we), .addr(tag_a), .wdata(tag_wd), .rdata(tag_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGES)) u_next (
        .clk(clk), .we(nx_we), .addr(nx_a), .wdata(nx_wd), .rdata(nx_rd));
    bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::PAGES)) u_prev (
        .clk(clk), .we(pv_we), .addr(pv_a), .wdata(pv_wd), .rdata(pv_rd));

    // Round request size up to a level, one page minimum.
    logic [5:0] shift;
    logic [30:0] bm1;
    always_comb
    begin
        bm1 = in_bytes - 31'd1;
        shift = 6'd0;
        if (in_bytes > 31'd1)
        begin
            for (int i = 0; i < 31; i++)
            begin
                if (bm1[i]) shift = 6'(i + 1);
            end
        end
        if (shift < 6'(bpa_pkg::PAGE_SHIFT)) shift = 6'(bpa_pkg::PAGE_SHIFT);
    end
    logic [5:0] req_full;
    assign req_full = shift - 6'(bpa_pkg::PAGE_SHIFT);

    logic [3:0] top;
    assign top = eff_levels - 4'd1;
    logic [PW:0] pool_pages;
    assign pool_pages = (PW+1)'(1) << top;

    logic [LW-1:0] head_cur;
    assign head_cur = head_reg[cur_reg];
    // Head of the level one below cur, the level a split pushes onto.
    logic [LW-1:0] old_h;
    assign old_h = head_reg[cur_reg - 4'd1];
    logic [PW-1:0] half;
    assign half = blk_reg + PW'((PW+1)'(1) << (cur_reg - 4'd1));
    logic [PW:0] bud_w;
    assign bud_w = {1'b0, off_reg ^ PW'((PW+1)'(1) << cur_reg)};

    // Status toward the controller.
    always_comb
    begin
        stat = '0;
        stat.clear_done = clr_reg == (PW+1)'(bpa_pkg::PAGES - 1);
        stat.scan_hit   = !head_cur[PW];
        stat.scan_end   = cur_reg == top;
        stat.too_large  = big_reg;
        stat.split_done = cur_reg == req_reg;
        stat.fbad       = ({1'b0, off_reg} >= pool_pages)
                       || !tag_rd[5] || !tag_rd[4];
        stat.merge_end  = (cur_reg + 4'd1 >= eff_levels) || (bud_w >= pool_pages);
        stat.merge_ok   = tag_rd == (bpa_pkg::TAG_START | {2'b0, cur_reg});
        stat.sub_done   = 1'b1;
    end

    // Memory command decode. Removal is split: sub 0 reads links, sub 1 latches them,
    // sub 2 patches neighbors (next of prev, prev of next).
    logic [PW-1:0] rm_pg;
    always_comb
    begin
        tag_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        tag_a = '0; nx_a = '0; pv_a = '0;
        tag_wd = '0; nx_wd = '0; pv_wd = '0;
        rm_pg = (cmd.op == bpa_pkg::OP_A_RM) ? blk_reg : bud_reg;
        unique case (cmd.op)
            bpa_pkg::OP_CLEAR:
            begin
                tag_we = 1'b1; tag_a = clr_reg[PW-1:0];
            end
            bpa_pkg::OP_INIT:
            begin
                tag_we = 1'b1; tag_a = '0; tag_wd = bpa_pkg::TAG_START | {2'b0, top};
                nx_we = 1'b1; nx_a = '0; nx_wd = bpa_pkg::NIL;
                pv_we = 1'b1; pv_a = '0; pv_wd = bpa_pkg::NIL;
            end
            bpa_pkg::OP_F_RD:
            begin
                tag_a = off_reg;
            end
            bpa_pkg::OP_B_RD:
            begin
                tag_a = bud_w[PW-1:0];
            end
            bpa_pkg::OP_A_RM, bpa_pkg::OP_RM:
            begin
                nx_a = rm_pg; pv_a = rm_pg;
                if (cmd.sub == 2'd2)
                begin
                    nx_a = p_reg[PW-1:0]; nx_we = !p_reg[PW]; nx_wd = n_reg;
                    pv_a = n_reg[PW-1:0]; pv_we = !n_reg[PW]; pv_wd = p_reg;
                    tag_a = bud_reg; tag_we = cmd.op == bpa_pkg::OP_RM;
                end
            end
            bpa_pkg::OP_SPLIT:
            begin
                if (cmd.sub == 2'd0)
                begin
                    tag_we = 1'b1; tag_a = half;
                    tag_wd = bpa_pkg::TAG_START | {2'b0, cur_reg - 4'd1};
                    nx_we = 1'b1; nx_a = half; nx_wd = old_h;
                    pv_we = 1'b1; pv_a = half; pv_wd = bpa_pkg::NIL;
                end
                else
                begin
                    pv_a = old_h[PW-1:0]; pv_we = !old_h[PW];
                    pv_wd = {1'b0, half};
                end
            end
            bpa_pkg::OP_A_DONE:
            begin
                tag_we = 1'b1; tag_a = blk_reg;
                tag_wd = bpa_pkg::TAG_START | bpa_pkg::TAG_ALLOC | {2'b0, req_reg};
            end
            bpa_pkg::OP_F_CHK:
            begin
                tag_we = !stat.fbad; tag_a = off_reg;
            end
            bpa_pkg::OP_PUSH:
            begin
                if (cmd.sub == 2'd0)
                begin
                    tag_we = 1'b1; tag_a = off_reg;
                    tag_wd = bpa_pkg::TAG_START | {2'b0, cur_reg};
                    nx_we = 1'b1; nx_a = off_reg; nx_wd = head_cur;
                    pv_we = 1'b1; pv_a = off_reg; pv_wd = bpa_pkg::NIL;
                end
                else
                begin
                    pv_a = head_cur[PW-1:0]; pv_we = !head_cur[PW];
                    pv_wd = {1'b0, off_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // Free list heads; split sub 1 moves the pushed half to the head of cur-1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bpa_pkg::SLOTS; i++) head_reg[i] <= bpa_pkg::NIL;
            clr_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                bpa_pkg::OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                bpa_pkg::OP_INIT:
                begin
                    clr_reg <= '0;
                    for (int i = 0; i < bpa_pkg::SLOTS; i++)
                    begin
                        head_reg[i] <= (4'(i) == top) ? '0 : bpa_pkg::NIL;
                    end
                end
                bpa_pkg::OP_A_RM, bpa_pkg::OP_RM:
                    if (cmd.sub == 2'd2 && p_reg[PW])
                    begin
                        head_reg[cur_reg] <= n_reg;
                    end
                bpa_pkg::OP_SPLIT:
                    if (cmd.sub == 2'd1)
                    begin
                        head_reg[cur_reg - 4'd1] <= {1'b0, half};
                    end
                bpa_pkg::OP_PUSH:
                    if (cmd.sub == 2'd1)
                    begin
                        head_reg[cur_reg] <= {1'b0, off_reg};
                    end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bpa_pkg::OP_LOAD:
            begin
                req_reg <= req_full[3:0];
                cur_reg <= req_full[3:0];
                off_reg <= in_page;
                big_reg <= req_full > {2'b0, top};
                cmd_reg <= in_command;
            end
            bpa_pkg::OP_SCAN:
            begin
                if (!stat.scan_hit) cur_reg <= cur_reg + 4'd1;
                blk_reg <= head_cur[PW-1:0];
            end
            bpa_pkg::OP_A_RM, bpa_pkg::OP_RM:
            begin
                if (cmd.sub == 2'd1)
                begin
                    n_reg <= nx_rd; p_reg <= pv_rd;
                end
                if (cmd.sub == 2'd2 && cmd.op == bpa_pkg::OP_RM)
                begin
                    if (bud_reg < off_reg) off_reg <= bud_reg;
                    cur_reg <= cur_reg + 4'd1;
                end
            end
            bpa_pkg::OP_SPLIT:
                if (cmd.sub == 2'd1)
                begin
                    cur_reg <= cur_reg - 4'd1;
                end
            bpa_pkg::OP_F_CHK: cur_reg <= tag_rd[3:0];
            bpa_pkg::OP_B_RD: bud_reg <= bud_w[PW-1:0];
            bpa_pkg::OP_A_DONE:
            begin
                rs_reg <= bpa_pkg::ST_OK; rp_reg <= blk_reg; rl_reg <= req_reg;
            end
            bpa_pkg::OP_PUSH:
            begin
                rs_reg <= bpa_pkg::ST_OK; rp_reg <= off_reg; rl_reg <= cur_reg;
            end
            bpa_pkg::OP_FAIL:
            begin
                rs_reg <= cmd_reg ? bpa_pkg::ST_BAD : bpa_pkg::ST_FULL;
                rp_reg <= '0; rl_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign res_status = rs_reg;
    assign res_page   = rp_reg;
    assign res_level  = rl_reg;
endmodule
`default_nettype wire

### src/bpa_controller.sv
// Controller: sequences allocate and free operations over the datapath.
`default_nettype none
module bpa_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           reinit,
    input  wire logic           in_fire,
    input  wire logic           in_command,
    input  wire logic           out_fire,
    input  wire bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t       cmd,
    output logic                in_rdy,
    output logic                out_vld
);
    bpa_pkg::state_t state_reg, state_next;
    logic [1:0] sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_CLEAR;
            sub_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sub_next   = '0;
        cmd.op     = bpa_pkg::OP_NONE;
        cmd.sub    = sub_reg;
        in_rdy     = 1'b0;
        out_vld    = 1'b0;
        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                cmd.op = bpa_pkg::OP_CLEAR;
                if (stat.clear_done) state_next = bpa_pkg::S_A_DONE;
            end
            bpa_pkg::S_IDLE:
            begin
                in_rdy = !reinit;
                if (reinit) state_next = bpa_pkg::S_CLEAR;
                else if (in_fire)
                begin
                    cmd.op = bpa_pkg::OP_LOAD;
                    state_next = in_command ? bpa_pkg::S_F_RD : bpa_pkg::S_A_SCAN;
                end
            end
            bpa_pkg::S_A_SCAN:
            begin
                cmd.op = bpa_pkg::OP_SCAN;
                if (stat.too_large) begin cmd.op = bpa_pkg::OP_FAIL; state_next = bpa_pkg::S_OUT; end
                else if (stat.scan_hit) state_next = bpa_pkg::S_A_RM;
                else if (stat.scan_end) begin cmd.op = bpa_pkg::OP_FAIL; state_next = bpa_pkg::S_OUT; end
            end
            bpa_pkg::S_A_RM:
            begin
                cmd.op = bpa_pkg::OP_A_RM;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2) begin sub_next = '0; state_next = bpa_pkg::S_A_SPLIT; end
            end
            bpa_pkg::S_A_SPLIT:
            begin
                if (stat.split_done)
                begin
                    cmd.op = bpa_pkg::OP_A_DONE;
                    state_next = bpa_pkg::S_OUT;
                end
                else
                begin
                    cmd.op = bpa_pkg::OP_SPLIT;
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd1) sub_next = '0;
                end
            end
            bpa_pkg::S_A_DONE:
            begin
                // Serves only as pool init after a clearing pass.
                cmd.op = bpa_pkg::OP_INIT;
                state_next = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_F_RD:
            begin
                cmd.op = bpa_pkg::OP_F_RD;
                state_next = bpa_pkg::S_F_WAIT;
            end
            bpa_pkg::S_F_WAIT:
            begin
                cmd.op = bpa_pkg::OP_F_RD;
                state_next = bpa_pkg::S_F_CHK;
            end
            bpa_pkg::S_F_CHK:
            begin
                cmd.op = bpa_pkg::OP_F_CHK;
                if (stat.fbad) begin cmd.op = bpa_pkg::OP_FAIL; state_next = bpa_pkg::S_OUT; end
                else state_next = bpa_pkg::S_F_BUD;
            end
            bpa_pkg::S_F_BUD:
            begin
                if (stat.merge_end) state_next = bpa_pkg::S_F_PUSH;
                else begin cmd.op = bpa_pkg::OP_B_RD; state_next = bpa_pkg::S_F_BWAIT; end
            end
            bpa_pkg::S_F_BWAIT:
            begin
                cmd.op = bpa_pkg::OP_B_RD;
                state_next = bpa_pkg::S_F_BCHK;
            end
            bpa_pkg::S_F_BCHK:
            begin
                state_next = stat.merge_ok ? bpa_pkg::S_F_RM : bpa_pkg::S_F_PUSH;
            end
            bpa_pkg::S_F_RM:
            begin
                cmd.op = bpa_pkg::OP_RM;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2) begin sub_next = '0; state_next = bpa_pkg::S_F_BUD; end
            end
            bpa_pkg::S_F_PUSH:
            begin
                cmd.op = bpa_pkg::OP_PUSH;
                sub_next = 2'd1;
                if (sub_reg == 2'd1) begin sub_next = '0; state_next = bpa_pkg::S_OUT; end
            end
            bpa_pkg::S_OUT:
            begin
                out_vld = 1'b1;
                if (out_fire) state_next = bpa_pkg::S_IDLE;
            end
            default: state_next = bpa_pkg::S_CLEAR;
        endcase
    end

    logic unused;
    assign unused = stat.sub_done;
endmodule
`default_nettype wire

### src/buddy_page_allocator.sv
// Top level of the buddy page allocator: APB config, channels, assertions.
// Time to result grows with each level split on allocate and each merged level on free,
// set by single-port RAM reads; a too-large allocate or a bad free ends early.
// One item in flight; the next input beat can be taken in the cycle after the result beat.
// Reset (and any pool_levels write) runs a clearing pass over every tag RAM entry,
// then a pool init step, before the first item is accepted.
`default_nettype none
`include "buddy_page_allocator_defines.svh"
module buddy_page_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [30:0] request_bytes,
    input  wire logic [9:0]  free_page,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [9:0]       block_page,
    output logic [3:0]       block_level
);
    logic [3:0] levels_reg;
    logic       reinit_reg;
    logic       wr;
    assign wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = {28'd0, levels_reg};

    bpa_pkg::cmd_t  cmd;
    bpa_pkg::stat_t stat;
    logic u_ctl_clearing;
    assign u_ctl_clearing = cmd.op == bpa_pkg::OP_CLEAR;

    // Hold the raw register; a write of register 0 requests a pool rebuild.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= 4'd11;
            reinit_reg <= 1'b0;
        end
        else
        begin
            if (wr && paddr == 1'b0)
            begin
                levels_reg <= pwdata[3:0];
                reinit_reg <= 1'b1;
            end
            else if (reinit_reg && u_ctl_clearing)
            begin
                reinit_reg <= 1'b0;
            end
        end
    end

    // Saturate the level count into the range the pool supports.
    logic [3:0] eff_levels;
    always_comb
    begin
        eff_levels = levels_reg;
        if (eff_levels < 4'd1) eff_levels = 4'd1;
        if (eff_levels > 4'(bpa_pkg::MAX_LEVELS)) eff_levels = 4'(bpa_pkg::MAX_LEVELS);
    end

    // Input is taken only while idle and no rebuild is pending; the result
    // beat is only offered in the output state, so ready alone completes it.
    bpa_controller u_ctl (
        .clk(clk), .rst_n(rst_n), .reinit(reinit_reg),
        .in_fire(in_valid && !reinit_reg), .in_command(command),
        .out_fire(out_ready), .stat(stat), .cmd(cmd),
        .in_rdy(in_ready), .out_vld(out_valid));

    bpa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .eff_levels(eff_levels),
        .in_command(command), .in_bytes(request_bytes), .in_page(free_page),
        .stat(stat), .res_status(status), .res_page(block_page),
        .res_level(block_level));

    `BPA_ASSERT_NEVER(a_no_both, clk, rst_n, in_ready && out_valid)
    `BPA_ASSERT_IMPL(a_ok_level, clk, rst_n,
        (out_valid && status == bpa_pkg::ST_OK) |-> (block_level < eff_levels))
    `BPA_ASSERT_IMPL(a_fail_zero, clk, rst_n,
        (out_valid && status != bpa_pkg::ST_OK) |-> (block_page == 10'd0))
endmodule
`default_nettype wire

### test/buddy_page_allocator_tb.sv
// Testbench for the buddy page allocator: directed and random beats checked against a predictor.
`default_nettype none
module buddy_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic [0:0] REG_POOL_LEVELS = 1'b0;
    localparam logic [5:0] LEVEL_BITS = 6'h0F;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] page;
        logic [3:0] level;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic        command;
    logic [30:0] request_bytes;
    logic [9:0]  free_page;
    logic        out_valid, out_ready;
    logic [1:0]  status;
    logic [9:0]  block_page;
    logic [3:0]  block_level;

    buddy_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .request_bytes(request_bytes), .free_page(free_page),
        .out_valid(out_valid), .out_ready(out_ready), .status(status),
        .block_page(block_page), .block_level(block_level)
    );

    // Shadow copy of the allocator state.
    logic [5:0]  tag_mem [bpa_pkg::PAGES];
    logic [10:0] head_mem [bpa_pkg::SLOTS];
    logic [10:0] next_mem [bpa_pkg::PAGES];
    logic [10:0] prev_mem [bpa_pkg::PAGES];
    int unsigned levels_eff;

    outcome_t    pending_q[$];   // results still owed by the block
    logic [9:0]  owned_q[$];     // pages that start allocated blocks
    int          errors;
    bit          quiet_out;      // hold out_ready high when set

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ---------------- predictor ----------------
    task automatic list_push(input int unsigned lv, input logic [10:0] pg);
        logic [10:0] h;
        h = head_mem[lv];
        next_mem[pg[9:0]] = h;
        prev_mem[pg[9:0]] = bpa_pkg::NIL;
        if (h != bpa_pkg::NIL) prev_mem[h[9:0]] = pg;
        head_mem[lv] = pg;
    endtask

    task automatic list_unlink(input int unsigned lv, input logic [10:0] pg);
        logic [10:0] n, p;
        n = next_mem[pg[9:0]];
        p = prev_mem[pg[9:0]];
        if (p != bpa_pkg::NIL) next_mem[p[9:0]] = n;
        else head_mem[lv] = n;
        if (n != bpa_pkg::NIL) prev_mem[n[9:0]] = p;
    endtask

    // Rebuild the pool as one free top-level block, as a register write does.
    task automatic pool_rebuild(input logic [3:0] lv_reg);
        levels_eff = (lv_reg == 0) ? 1 : ((lv_reg > 11) ? 11 : lv_reg);
        for (int i = 0; i < bpa_pkg::PAGES; i++)
        begin
            tag_mem[i] = '0;
            next_mem[i] = '0;
            prev_mem[i] = '0;
        end
        for (int i = 0; i < bpa_pkg::SLOTS; i++) head_mem[i] = bpa_pkg::NIL;
        list_push(levels_eff - 1, 11'd0);
        tag_mem[0] = bpa_pkg::TAG_START | 6'(levels_eff - 1);
        owned_q.delete();
    endtask

    task automatic predict_alloc(input logic [30:0] bytes, output outcome_t res);
        int unsigned sh, want, cur;
        logic [10:0] blk, half;
        res = '0;
        sh = 0;
        while (sh < 40 && (64'd1 << sh) < {33'd0, bytes}) sh++;
        if (sh < bpa_pkg::PAGE_SHIFT) sh = bpa_pkg::PAGE_SHIFT;
        want = sh - bpa_pkg::PAGE_SHIFT;
        if (want > levels_eff - 1)
        begin
            res.status = bpa_pkg::ST_FULL;
            return;
        end
        for (cur = want; cur < levels_eff; cur++)
            if (head_mem[cur] != bpa_pkg::NIL) break;
        if (cur >= levels_eff)
        begin
            res.status = bpa_pkg::ST_FULL;
            return;
        end
        blk = head_mem[cur];
        list_unlink(cur, blk);
        while (cur > want)
        begin
            cur--;
            half = blk + (11'd1 << cur);
            list_push(cur, half);
            tag_mem[half[9:0]] = bpa_pkg::TAG_START | 6'(cur);
        end
        tag_mem[blk[9:0]] = bpa_pkg::TAG_START | bpa_pkg::TAG_ALLOC | 6'(want);
        res.status = bpa_pkg::ST_OK;
        res.page = blk[9:0];
        res.level = 4'(want);
        owned_q.push_back(blk[9:0]);
    endtask

    task automatic predict_free(input logic [9:0] pg, output outcome_t res);
        int unsigned cur, pool_pages;
        logic [10:0] off, bud;
        logic [5:0] t;
        res = '0;
        pool_pages = 1 << (levels_eff - 1);
        t = (pg < pool_pages) ? tag_mem[pg] : 6'd0;
        if ((t & bpa_pkg::TAG_START) == 0 || (t & bpa_pkg::TAG_ALLOC) == 0)
        begin
            res.status = bpa_pkg::ST_BAD;
            return;
        end
        cur = t & LEVEL_BITS;
        off = {1'b0, pg};
        tag_mem[pg] = '0;
        while (cur + 1 < levels_eff)
        begin
            bud = off ^ (11'd1 << cur);
            if (bud >= pool_pages) break;
            if (tag_mem[bud[9:0]] != (bpa_pkg::TAG_START | 6'(cur))) break;
            list_unlink(cur, bud);
            tag_mem[bud[9:0]] = '0;
            if (bud < off) off = bud;
            cur++;
        end
        list_push(cur, off);
        tag_mem[off[9:0]] = bpa_pkg::TAG_START | 6'(cur);
        res.status = bpa_pkg::ST_OK;
        res.page = off[9:0];
        res.level = 4'(cur);
        foreach (owned_q[i])
            if (owned_q[i] == pg)
            begin
                owned_q.delete(i);
                break;
            end
    endtask

    // ---------------- stimulus ----------------
    // Send one beat, then optionally drop valid for a random gap.
    task automatic send_beat(input logic cmd, input logic [30:0] bytes,
                             input logic [9:0] pg);
        outcome_t res;
        int r, gap;
        in_valid <= 1'b1;
        command <= cmd;
        request_bytes <= bytes;
        free_page <= pg;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_ALLOC) predict_alloc(bytes, res);
        else predict_free(pg, res);
        pending_q.push_back(res);
        r = $urandom_range(0, 99);
        if (r < 50) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    // Write pool_levels while idle; the block then reruns its clearing pass.
    task automatic set_pool_levels(input logic [3:0] lv);
        drain_results();
        repeat (100) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_POOL_LEVELS;
        pwdata <= {$urandom_range(0, 1) ? 28'hFFFFFFF : 28'h0, lv};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pool_rebuild(lv);
    endtask

    task automatic test_directed();
        set_pool_levels(4'd11);
        send_beat(CMD_ALLOC, 31'd0, 10'd0);
        send_beat(CMD_ALLOC, 31'd1, 10'd0);
        send_beat(CMD_ALLOC, 31'd4097, 10'd0);
        send_beat(CMD_ALLOC, 31'h7FFFFFFF, 10'h3FF);  // too large
        send_beat(CMD_FREE, 31'h7FFFFFFF, 10'd1);     // free second allocation's page
        send_beat(CMD_FREE, 31'd0, 10'd1);            // double free
        send_beat(CMD_FREE, 31'd0, 10'h3FF);          // not a block start
        send_beat(CMD_FREE, 31'd0, 10'd0);
        send_beat(CMD_FREE, 31'd0, 10'd2);            // merges up
        send_beat(CMD_ALLOC, 31'd4194304, 10'd0);     // whole pool
        send_beat(CMD_ALLOC, 31'd4096, 10'd0);        // exhausted
        send_beat(CMD_FREE, 31'd0, 10'd0);
        set_pool_levels(4'd1);
        send_beat(CMD_ALLOC, 31'd4096, 10'd0);
        send_beat(CMD_ALLOC, 31'd0, 10'd0);           // exhausted
        send_beat(CMD_FREE, 31'd0, 10'd1);            // beyond the pool
        send_beat(CMD_FREE, 31'd0, 10'd0);
        send_beat(CMD_ALLOC, 31'd4097, 10'd0);        // too large for one page
        set_pool_levels(4'd0);                        // acts as one level
        send_beat(CMD_ALLOC, 31'd100, 10'd0);
        send_beat(CMD_FREE, 31'd0, 10'd0);
        set_pool_levels(4'd15);                       // saturates to the full pool
        send_beat(CMD_ALLOC, 31'd2097153, 10'd0);
        send_beat(CMD_FREE, 31'd0, 10'd0);
    endtask

    // Mostly well-formed alloc/free traffic, with some noise.
    task automatic test_random_mix(input logic [3:0] lv, input int count);
        int r;
        logic [30:0] bytes;
        logic [9:0] pg;
        int unsigned top_bytes;
        set_pool_levels(lv);
        top_bytes = 4096 << (levels_eff - 1);
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 60) bytes = 31'($urandom_range(0, top_bytes / 8));
                else if (r < 90) bytes = 31'($urandom_range(0, top_bytes));
                else bytes = 31'($urandom());
                send_beat(CMD_ALLOC, bytes, 10'($urandom()));
            end
            else if (r < 90 && owned_q.size() != 0)
            begin
                pg = owned_q[$urandom_range(0, owned_q.size() - 1)];
                send_beat(CMD_FREE, 31'($urandom()), pg);
            end
            else
                send_beat(CMD_FREE, 31'($urandom()), 10'($urandom()));
        end
    endtask

    // Pause the sender until the block has returned everything, twice mid-stream.
    task automatic test_pressure();
        test_random_mix(4'd6, 40);
        drain_results();
        test_random_mix(4'd11, 40);
        drain_results();
        repeat (30) @(posedge clk);
        send_beat(CMD_ALLOC, 31'd8192, 10'd0);
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
                report_mismatch("unexpected result beat, status", status, 0);
            else
            begin
                exp_r = pending_q.pop_front();
                if (status !== exp_r.status)
                    report_mismatch("status", status, exp_r.status);
                if (block_page !== exp_r.page)
                    report_mismatch("block_page", block_page, exp_r.page);
                if (block_level !== exp_r.level)
                    report_mismatch("block_level", block_level, exp_r.level);
            end
        end
    end

    // Receiver back-pressure: mostly short stalls, a few long ones.
    int stall_left;
    always @(posedge clk)
    begin
        int r;
        if (quiet_out)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10) stall_left = $urandom_range(1, 3);
            else if (r < 12) stall_left = $urandom_range(10, 40);
            out_ready <= (r >= 12);
        end
    end

    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        errors = 0;
        stall_left = 0;
        quiet_out = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        command = CMD_ALLOC;
        request_bytes = '0;
        free_page = '0;
        out_ready = 1'b0;
        pool_rebuild(4'd11);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pressure();
        test_random_mix(4'd3, 150);
        quiet_out = 1'b1;           // a stretch with no receiver stalls
        test_random_mix(4'd5, 150);
        quiet_out = 1'b0;
        test_random_mix(4'd11, 250);
        test_random_mix(4'd2, 100);
        test_random_mix(4'd8, 250);
        drain_results();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
